>>> rtl/ready_queue_ordered_insert_macros.svh
// Assertion macros for the ready queue blocks.
// Needs clk and arst_n in the scope of use.
`ifndef READY_QUEUE_ORDERED_INSERT_MACROS_SVH
`define READY_QUEUE_ORDERED_INSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RQOI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RQOI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rqoi_pkg.sv
// Shared types, codes and sizes for the ordered ready queue.
// No dependencies.
package rqoi_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int OCC_W = 5;

	localparam logic       OP_INSERT = 1'b0;
	localparam logic       OP_POP    = 1'b1;

	localparam logic [1:0] ORD_ARRIVAL = 2'd0;
	localparam logic [1:0] ORD_SJF     = 2'd1;
	localparam logic [1:0] ORD_PRIO    = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic        mode;
		logic [7:0]  process_id;
		logic [15:0] remaining_work;
		logic [7:0]  priority_req;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             head_valid;
		logic [7:0]       head_id;
		logic [15:0]      head_work;
		logic [7:0]       head_priority;
		logic [OCC_W-1:0] occupancy;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] work;
		logic [7:0]  prio;
	} entry_t;

	typedef struct packed {
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} mem_req_t;

	function automatic logic [15:0] key_of(entry_t e, logic [1:0] md);
		key_of = (md == ORD_SJF) ? e.work : {8'd0, e.prio};
	endfunction

endpackage

>>> rtl/rqoi_mem.sv
// Entry storage: one write port, one read port with registered data.
// Depends on rqoi_pkg.
module rqoi_mem (
	input  logic              clk,
	input  rqoi_pkg::mem_req_t req,
	output rqoi_pkg::entry_t   rdata
);
	import rqoi_pkg::*;

	entry_t mem_q [QUEUE_DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		rdata_q <= mem_q[req.rd_addr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/rqoi_ctrl.sv
// Sequencer for insert scan, entry shifting and pop, with the key comparator.
// Depends on rqoi_pkg; drives rqoi_mem.
module rqoi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          order_mode,
	input  logic                in_valid,
	output logic                in_ready,
	input  rqoi_pkg::in_item_t  in_item,
	output logic                fin_valid,
	input  logic                fin_take,
	output rqoi_pkg::out_item_t fin_item,
	output rqoi_pkg::mem_req_t  mem_req,
	input  rqoi_pkg::entry_t    mem_rdata
);
	import rqoi_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_SH_RD, S_SH_WR, S_INS_WR,
		S_POP_HEAD, S_POP_RD, S_POP_WR, S_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] j_q;
	entry_t           word_q;
	out_item_t        res_q;
	logic             cmp_gt;
	logic [1:0]       idle_status;

	assign in_ready  = (state_q == S_IDLE);
	assign fin_valid = (state_q == S_FIN);
	assign fin_item  = res_q;
	assign cmp_gt    = key_of(mem_rdata, order_mode) > key_of(word_q, order_mode);

	// status known at accept: drop on full insert, flag empty pop
	always_comb begin
		idle_status = ST_OK;
		if (in_item.mode == OP_INSERT && cnt_q == CNT_W'(QUEUE_DEPTH)) begin
			idle_status = ST_FULL;
		end else if (in_item.mode == OP_POP && cnt_q == '0) begin
			idle_status = ST_EMPTY;
		end
	end

	always_comb begin
		mem_req.rd_addr = '0;
		mem_req.wr_en   = 1'b0;
		mem_req.wr_addr = j_q;
		mem_req.wr_data = mem_rdata;
		case (state_q)
			S_SCAN:   mem_req.rd_addr = idx_q + IDX_W'(1);
			S_SH_RD:  mem_req.rd_addr = j_q - IDX_W'(1);
			S_POP_RD: mem_req.rd_addr = j_q + IDX_W'(1);
			S_SH_WR, S_POP_WR: mem_req.wr_en = 1'b1;
			S_INS_WR: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = pos_q;
				mem_req.wr_data = word_q;
			end
			default: mem_req.rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			pos_q   <= '0;
			j_q     <= '0;
			word_q  <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						word_q <= {in_item.process_id, in_item.remaining_work,
							in_item.priority_req};
						idx_q  <= '0;
						j_q    <= '0;
						res_q  <= '{status: idle_status, head_valid: 1'b0, head_id: '0,
							head_work: '0, head_priority: '0, occupancy: OCC_W'(cnt_q)};
						if (in_item.mode == OP_INSERT) begin
							if (cnt_q == CNT_W'(QUEUE_DEPTH)) begin
								state_q <= S_FIN;
							end else if ((order_mode == ORD_SJF || order_mode == ORD_PRIO)
								&& cnt_q != '0) begin
								state_q <= S_SCAN;
							end else begin
								pos_q   <= IDX_W'(cnt_q);
								state_q <= S_INS_WR;
							end
						end else begin
							if (cnt_q == '0) begin
								state_q <= S_FIN;
							end else begin
								state_q <= S_POP_HEAD;
							end
						end
					end
				end
				S_SCAN: begin
					// stop at the first entry with a strictly larger key
					if (cmp_gt) begin
						pos_q   <= idx_q;
						j_q     <= IDX_W'(cnt_q);
						state_q <= S_SH_RD;
					end else if (CNT_W'(idx_q) + CNT_W'(1) == cnt_q) begin
						pos_q   <= IDX_W'(cnt_q);
						state_q <= S_INS_WR;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_SH_RD: state_q <= S_SH_WR;
				S_SH_WR: begin
					// move tail entries up one slot, from the top down
					j_q <= j_q - IDX_W'(1);
					if (j_q - IDX_W'(1) == pos_q) begin
						state_q <= S_INS_WR;
					end else begin
						state_q <= S_SH_RD;
					end
				end
				S_INS_WR: begin
					cnt_q           <= cnt_q + CNT_W'(1);
					res_q.occupancy <= OCC_W'(cnt_q + CNT_W'(1));
					state_q         <= S_FIN;
				end
				S_POP_HEAD: begin
					res_q.head_valid    <= 1'b1;
					res_q.head_id       <= mem_rdata.id;
					res_q.head_work     <= mem_rdata.work;
					res_q.head_priority <= mem_rdata.prio;
					if (cnt_q == CNT_W'(1)) begin
						cnt_q           <= '0;
						res_q.occupancy <= '0;
						state_q         <= S_FIN;
					end else begin
						state_q <= S_POP_RD;
					end
				end
				S_POP_RD: state_q <= S_POP_WR;
				S_POP_WR: begin
					// advance the remaining entries toward the head
					j_q <= j_q + IDX_W'(1);
					if (CNT_W'(j_q) + CNT_W'(2) == cnt_q) begin
						cnt_q           <= cnt_q - CNT_W'(1);
						res_q.occupancy <= OCC_W'(cnt_q - CNT_W'(1));
						state_q         <= S_FIN;
					end else begin
						state_q <= S_POP_RD;
					end
				end
				S_FIN: begin
					if (fin_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/ready_queue_ordered_insert.sv
// Top level of the ordered ready queue: order mode register, output register.
// Depends on rqoi_pkg, rqoi_mem, rqoi_ctrl and the assertion macro header.
//
// Ready queue of up to QUEUE_DEPTH process entries kept in order in a memory
// with one read and one write port, head at slot 0. An item inserts (placed per
// order_mode: arrival order appends, shortest work or priority mode goes in
// front of the first entry with a strictly larger key) or pops the head. Each
// item gives one result item. Items are handled one at a time; in_ready drops
// while one is in work. The one memory read port and the one key comparator
// walk the entries. The next item may be accepted while a result waits in the
// output register.
`include "ready_queue_ordered_insert_macros.svh"

module ready_queue_ordered_insert (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  rqoi_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output rqoi_pkg::out_item_t out_item
);
	import rqoi_pkg::*;

	logic       [1:0] order_mode_q;
	logic             out_valid_q;
	out_item_t        out_item_q;
	logic             fin_valid;
	logic             fin_take;
	out_item_t        fin_item;
	mem_req_t         mem_req;
	entry_t           mem_rdata;

	rqoi_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	rqoi_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.order_mode (order_mode_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.fin_valid  (fin_valid),
		.fin_take   (fin_take),
		.fin_item   (fin_item),
		.mem_req    (mem_req),
		.mem_rdata  (mem_rdata)
	);

	assign fin_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= ORD_ARRIVAL;
			out_valid_q  <= 1'b0;
			out_item_q   <= '0;
		end else begin
			if (cfg_we) begin
				order_mode_q <= cfg_wdata;
			end
			if (fin_valid && fin_take) begin
				out_valid_q <= 1'b1;
				out_item_q  <= fin_item;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`RQOI_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready held after accept")
	`RQOI_ASSERT_NOW(a_head_only_ok, out_valid && out_item.head_valid, out_item.status == ST_OK, "head returned with error status")
	`RQOI_ASSERT_NOW(a_empty_no_head, out_valid && out_item.status == ST_EMPTY, !out_item.head_valid && out_item.occupancy == '0, "empty pop returned a head")

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the ordered ready queue: a scoreboard class mirrors the queue
// and checks each result item in order. Depends on rqoi_pkg and ready_queue_ordered_insert.

import rqoi_pkg::*;

class queue_scoreboard;
	entry_t      slots[QUEUE_DEPTH];
	int unsigned fill;
	logic [1:0]  order;
	out_item_t   pending[$];
	int unsigned errors;
	int unsigned items_seen;
	int unsigned entries_popped;
	int unsigned full_drops;
	int unsigned empty_pops;

	function new();
		fill = 0;
		order = ORD_ARRIVAL;
		errors = 0;
		items_seen = 0;
		entries_popped = 0;
		full_drops = 0;
		empty_pops = 0;
	endfunction

	function void set_order(logic [1:0] m);
		order = m;
	endfunction

	// True when an existing entry must yield its place to the incoming one.
	function bit yields_to(entry_t resident, entry_t incoming);
		if (order == ORD_SJF)
			return resident.work > incoming.work;
		return resident.prio > incoming.prio;
	endfunction

	function void note_item(in_item_t it);
		out_item_t r;
		entry_t    e;
		int unsigned pos;
		r = '0;
		items_seen++;
		if (it.mode == OP_INSERT) begin
			if (fill >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
				full_drops++;
			end else begin
				e.id = it.process_id;
				e.work = it.remaining_work;
				e.prio = it.priority_req;
				pos = fill;
				if (order == ORD_SJF || order == ORD_PRIO) begin
					for (int i = 0; i < fill; i++) begin
						if (yields_to(slots[i], e)) begin
							pos = i;
							break;
						end
					end
				end
				for (int i = fill; i > pos; i--)
					slots[i] = slots[i-1];
				slots[pos] = e;
				fill++;
			end
		end else begin
			if (fill == 0) begin
				r.status = ST_EMPTY;
				empty_pops++;
			end else begin
				r.head_valid = 1'b1;
				r.head_id = slots[0].id;
				r.head_work = slots[0].work;
				r.head_priority = slots[0].prio;
				for (int i = 0; i + 1 < fill; i++)
					slots[i] = slots[i+1];
				fill--;
				entries_popped++;
			end
		end
		r.status = r.status;
		r.occupancy = OCC_W'(fill);
		pending.push_back(r);
	endfunction

	function void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	function void check_result(out_item_t got);
		out_item_t want;
		if (pending.size() == 0) begin
			errors++;
			$display("%0t: result item with nothing expected, actual %h", $time, got);
			return;
		end
		want = pending.pop_front();
		compare_field("status", 32'(want.status), 32'(got.status));
		compare_field("head_valid", 32'(want.head_valid), 32'(got.head_valid));
		compare_field("head_id", 32'(want.head_id), 32'(got.head_id));
		compare_field("head_work", 32'(want.head_work), 32'(got.head_work));
		compare_field("head_priority", 32'(want.head_priority), 32'(got.head_priority));
		compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
	endfunction
endclass

module tb;
	localparam logic [1:0]  ORD_UNUSED = 2'd3;
	localparam int          SETTLE_CYCLES = 64;
	localparam int          PHASE_ITEMS = 125;
	localparam int          NUM_PHASES = 8;
	localparam int unsigned CYCLE_LIMIT = 600000;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cfg_we;
	logic [1:0] cfg_wdata;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	queue_scoreboard board;
	bit              quiet;
	int unsigned     cycles;
	logic [1:0]      phase_order[NUM_PHASES] = '{ORD_SJF, ORD_PRIO, ORD_UNUSED, ORD_ARRIVAL,
		ORD_PRIO, ORD_SJF, ORD_UNUSED, ORD_PRIO};

	ready_queue_ordered_insert dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(out_item);
	end

	// Hold the item until accepted; optionally idle first.
	task automatic send_item(input in_item_t it);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		board.note_item(it);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.pending.size() != 0);
	endtask

	task automatic set_order_mode(input logic [1:0] m);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_order(m);
	endtask

	task automatic run_result_sink();
		int n;
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 10);
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			n = $urandom_range(1, 40);
			repeat (n) @(posedge clk);
		end
	endtask

	// Small key ranges half the time so that ties are common.
	function automatic in_item_t make_item(bit filling);
		in_item_t it;
		it.mode = ($urandom_range(0, 99) < (filling ? 75 : 25)) ? OP_INSERT : OP_POP;
		it.process_id = 8'($urandom_range(0, 255));
		it.remaining_work = $urandom_range(0, 1) ? 16'($urandom_range(0, 7))
			: 16'($urandom_range(0, 65535));
		it.priority_req = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
			: 8'($urandom_range(0, 255));
		return it;
	endfunction

	initial begin
		in_item_t it;
		bit       filling;
		board = new();
		cycles <= 0;
		quiet <= 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		in_item <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pop, fill to full with field extremes, drop on full, pops.
		it = '0;
		it.mode = OP_POP;
		send_item(it);
		for (int i = 0; i < QUEUE_DEPTH + 1; i++) begin
			it = make_item(1'b1);
			it.mode = OP_INSERT;
			case (i)
				0: begin
					it.process_id = 8'h00;
					it.remaining_work = 16'h0000;
					it.priority_req = 8'h00;
				end
				1: begin
					it.process_id = 8'hFF;
					it.remaining_work = 16'hFFFF;
					it.priority_req = 8'hFF;
				end
				2: begin
					it.process_id = 8'hAA;
					it.remaining_work = 16'h5555;
					it.priority_req = 8'h55;
				end
				3: begin
					it.process_id = 8'h55;
					it.remaining_work = 16'hAAAA;
					it.priority_req = 8'hAA;
				end
				default: ;
			endcase
			send_item(it);
		end
		for (int i = 0; i < 2; i++) begin
			it = make_item(1'b0);
			it.mode = OP_POP;
			send_item(it);
		end

		// Random phases, one order setting each; the queue carries over between them.
		filling = 1'b1;
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_order_mode(phase_order[p]);
			if (p == NUM_PHASES - 1)
				quiet = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 19) == 0)
					filling = !filling;
				send_item(make_item(filling));
				if (!quiet && $urandom_range(0, 199) == 0)
					drain_results();
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		board.errors += board.pending.size();
		$display("covered %0d items over %0d order settings, reset mode included",
			board.items_seen, NUM_PHASES + 1);
		$display("  %0d entries popped, %0d inserts dropped on full, %0d pops on empty",
			board.entries_popped, board.full_drops, board.empty_pops);
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial run_result_sink();
endmodule
